/* rtl/iaie_pkg.sv */
// Package for the indexed array with insert and erase.
// Holds the operation and status codes, fixed field widths and the cell control word.
// No dependencies.
package iaie_pkg;

    // Fixed widths of the word fields.
    localparam int OP_W     = 3;
    localparam int INDEX_W  = 6;
    localparam int FIELD_W  = 32;
    localparam int FILL_W   = 7;
    localparam int STATUS_W = 2;

    // Highest number of cells that an index can address.
    localparam int INDEX_SPAN = 1 << INDEX_W;

    typedef enum logic [OP_W-1:0] {
        OP_READ      = 3'd0,
        OP_OVERWRITE = 3'd1,
        OP_INSERT    = 3'd2,
        OP_ERASE     = 3'd3,
        OP_APPEND    = 3'd4,
        OP_REMOVE    = 3'd5
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    // Control word broadcast to every cell of the row.
    typedef struct packed {
        logic               load_idx;    // write the new word at the index
        logic               shift_up;    // cells above the index take the left neighbour
        logic               shift_down;  // cells from the index up take the right neighbour
        logic               load_count;  // write the new word at the fill count
        logic [INDEX_W-1:0] idx;
    } cell_ctl_t;

endpackage

/* rtl/iaie_cell.sv */
// One storage cell of the array row.
// Holds a single entry and moves it to or from its neighbours. Depends on iaie_pkg.
module iaie_cell #(
    parameter int POS        = 0,
    parameter int DATA_WIDTH = 32,
    parameter int CW         = 7
) (
    input  logic                    clk,
    input  iaie_pkg::cell_ctl_t     ctl,
    input  logic [CW-1:0]           count,
    input  logic [DATA_WIDTH-1:0]   new_word,
    input  logic [DATA_WIDTH-1:0]   left_word,
    input  logic [DATA_WIDTH-1:0]   right_word,
    output logic [DATA_WIDTH-1:0]   word
);
    import iaie_pkg::*;

    logic [DATA_WIDTH-1:0] word_reg;
    logic [DATA_WIDTH-1:0] word_next;
    logic                  at_idx;
    logic                  above_idx;
    logic                  at_count;

    // Position of this cell relative to the index and the fill count.
    assign at_idx    = (int'(ctl.idx) == POS);
    assign above_idx = (POS > int'(ctl.idx));
    assign at_count  = (int'(count) == POS);

    // Select the entry this cell holds after the word.
    always_comb
    begin
        word_next = word_reg;
        if (ctl.load_idx && at_idx)
        begin
            word_next = new_word;
        end
        else if (ctl.shift_up && above_idx)
        begin
            word_next = left_word;
        end
        else if (ctl.shift_down && (above_idx || at_idx))
        begin
            word_next = right_word;
        end
        else if (ctl.load_count && at_count)
        begin
            word_next = new_word;
        end
    end

    // Entry storage; contents need no reset.
    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

/* rtl/iaie_ctrl.sv */
// Operation decoder for the indexed array.
// Checks bounds, forms the status and next fill count, and drives the cell controls.
// Depends on iaie_pkg.
module iaie_ctrl #(
    parameter int DEPTH = 64,
    parameter int CW    = 7
) (
    input  logic                              go,
    input  logic [iaie_pkg::OP_W-1:0]         operation,
    input  logic [iaie_pkg::INDEX_W-1:0]      index,
    input  logic [CW-1:0]                     count,
    output iaie_pkg::cell_ctl_t               ctl,
    output iaie_pkg::status_t                 status,
    output logic [CW-1:0]                     count_next,
    output logic                              read_ok
);
    import iaie_pkg::*;

    localparam int CMP_W = (CW > INDEX_W) ? CW : INDEX_W;

    logic [CMP_W-1:0] idx_x;
    logic [CMP_W-1:0] count_x;
    logic             full;
    logic             empty;

    assign idx_x   = CMP_W'(index);
    assign count_x = CMP_W'(count);
    assign full    = (count >= CW'(DEPTH));
    assign empty   = (count == '0);

    // Decode the operation with its bounds checks.
    always_comb
    begin
        ctl            = '0;
        ctl.idx        = index;
        status         = ST_OK;
        count_next     = count;
        read_ok        = 1'b0;
        case (op_t'(operation))
            OP_READ:
            begin
                if (idx_x >= count_x)
                    status = ST_RANGE;
                else
                    read_ok = 1'b1;
            end
            OP_OVERWRITE:
            begin
                if (idx_x >= count_x)
                    status = ST_RANGE;
                else
                    ctl.load_idx = go;
            end
            OP_INSERT:
            begin
                if (idx_x > count_x)
                    status = ST_RANGE;
                else if (full)
                    status = ST_FULL;
                else
                begin
                    ctl.load_idx = go;
                    ctl.shift_up = go;
                    count_next   = count + CW'(1);
                end
            end
            OP_ERASE:
            begin
                if (idx_x >= count_x)
                    status = ST_RANGE;
                else
                begin
                    ctl.shift_down = go;
                    count_next     = count - CW'(1);
                end
            end
            OP_APPEND:
            begin
                if (full)
                    status = ST_FULL;
                else
                begin
                    ctl.load_count = go;
                    count_next     = count + CW'(1);
                end
            end
            OP_REMOVE:
            begin
                if (empty)
                    status = ST_EMPTY;
                else
                    count_next = count - CW'(1);
            end
            default:
            begin
                status = ST_OK;
            end
        endcase
    end

endmodule

/* rtl/indexed_array_insert_erase_top.sv */
// Top level of the indexed array with insert and erase.
// Instantiates iaie_ctrl and a row of iaie_cell; depends on iaie_pkg.
//
//   Channel   Handshake                  Payload
//   input     in_valid / in_stall        operation, index, value
//   output    out_valid / out_stall      read_value, fill_count, status
//
// The row of cells shifts all entries at once, so insert and erase finish as fast
// as a read, and one word is taken per cycle while the input is not stalled.
// The result is captured in the output register as the word is taken.
// Reset empties the array at once; no clearing pass is needed.
// A stalled result holds the input off only while the output register is full.
module indexed_array_insert_erase_top #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [iaie_pkg::OP_W-1:0]         operation,
    input  logic [iaie_pkg::INDEX_W-1:0]      index,
    input  logic signed [iaie_pkg::FIELD_W-1:0] value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [iaie_pkg::FIELD_W-1:0] read_value,
    output logic [iaie_pkg::FILL_W-1:0]       fill_count,
    output logic [iaie_pkg::STATUS_W-1:0]     status
);
    import iaie_pkg::*;

    localparam int CW        = $clog2(DEPTH + 1);
    localparam int READ_SPAN = (DEPTH < INDEX_SPAN) ? DEPTH : INDEX_SPAN;
    localparam int RSEL_W    = $clog2(READ_SPAN);

    logic                  fire;
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    cell_ctl_t             ctl;
    status_t               op_status;
    logic                  read_ok;
    logic [DATA_WIDTH-1:0] new_word;
    logic [DATA_WIDTH-1:0] words [DEPTH];
    logic [DATA_WIDTH-1:0] rd_words [READ_SPAN];
    logic [DATA_WIDTH-1:0] rd_word;
    logic [FIELD_W-1:0]    rd_ext;

    logic                  out_valid_reg;
    logic [FIELD_W-1:0]    read_value_reg;
    logic [FILL_W-1:0]     fill_count_reg;
    logic [STATUS_W-1:0]   status_reg;

    // The input is held off only while a finished result waits.
    assign in_stall = out_valid_reg && out_stall;
    assign fire     = in_valid && !in_stall;

    // Incoming word fitted to the entry width, and the read word fitted back to the field width.
    generate
        if (DATA_WIDTH > FIELD_W)
        begin : g_wide
            assign new_word = {{(DATA_WIDTH - FIELD_W){value[FIELD_W-1]}}, value};
            assign rd_ext   = rd_word[FIELD_W-1:0];
        end
        else if (DATA_WIDTH == FIELD_W)
        begin : g_same
            assign new_word = value;
            assign rd_ext   = rd_word;
        end
        else
        begin : g_narrow
            assign new_word = value[DATA_WIDTH-1:0];
            assign rd_ext   = {{(FIELD_W - DATA_WIDTH){rd_word[DATA_WIDTH-1]}}, rd_word};
        end
    endgenerate

    iaie_ctrl #(
        .DEPTH (DEPTH),
        .CW    (CW)
    ) u_ctrl (
        .go         (fire),
        .operation  (operation),
        .index      (index),
        .count      (count_reg),
        .ctl        (ctl),
        .status     (op_status),
        .count_next (count_next),
        .read_ok    (read_ok)
    );

    // Row of cells; the ends take zero from outside the row.
    generate
        for (genvar i = 0; i < DEPTH; i++)
        begin : g_cell
            logic [DATA_WIDTH-1:0] left_w;
            logic [DATA_WIDTH-1:0] right_w;
            if (i == 0)
            begin : g_first
                assign left_w = '0;
            end
            else
            begin : g_left
                assign left_w = words[i-1];
            end
            if (i == DEPTH - 1)
            begin : g_last
                assign right_w = '0;
            end
            else
            begin : g_right
                assign right_w = words[i+1];
            end
            iaie_cell #(
                .POS        (i),
                .DATA_WIDTH (DATA_WIDTH),
                .CW         (CW)
            ) u_cell (
                .clk        (clk),
                .ctl        (ctl),
                .count      (count_reg),
                .new_word   (new_word),
                .left_word  (left_w),
                .right_word (right_w),
                .word       (words[i])
            );
        end
        for (genvar j = 0; j < READ_SPAN; j++)
        begin : g_rd
            assign rd_words[j] = words[j];
        end
    endgenerate

    // Read select over the cells an index can reach.
    assign rd_word = rd_words[index[RSEL_W-1:0]];

    // Fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (fire)
            count_reg <= count_next;
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (fire)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            read_value_reg <= read_ok ? rd_ext : '0;
            fill_count_reg <= FILL_W'(count_next);
            status_reg     <= op_status;
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_value = read_value_reg;
    assign fill_count = fill_count_reg;
    assign status     = status_reg;

endmodule

/* rtl/iaie_checker.sv */
// Port-level checks for the indexed array with insert and erase.
// Bound to indexed_array_insert_erase_top; depends on iaie_pkg.
module iaie_checker #(
    parameter int DEPTH = 64
) (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] read_value,
    input logic [6:0]  fill_count,
    input logic [1:0]  status
);
    import iaie_pkg::*;

    // A stalled result word holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(read_value)
            && $stable(fill_count) && $stable(status))
        else $error("result word changed while stalled");

    // A word with a status other than OK returns a zero value.
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> read_value == '0)
        else $error("rejected word returned data");

    // The fill count never passes the capacity; checked only for DEPTH up to 127.
    a_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (DEPTH > 127) || (int'(fill_count) <= DEPTH))
        else $error("fill count beyond capacity");

    // Empty and full answers agree with the count.
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_EMPTY |-> fill_count == '0)
        else $error("empty status with entries held");

    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_FULL |-> fill_count == 7'(DEPTH))
        else $error("full status below capacity");

endmodule

bind indexed_array_insert_erase_top iaie_checker #(
    .DEPTH (DEPTH)
) u_iaie_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .read_value (read_value),
    .fill_count (fill_count),
    .status     (status)
);
